// ===== rtl/pp5_pkg.sv =====
// ----------------------------------------------------------------------------
// pp5_pkg: shared constants, types and helpers for the Putnins P5 projection
// Fixed-point constants of the projection, register and action codes, the
// sideband record that travels along the pipeline, and sign/saturate helpers.
// ----------------------------------------------------------------------------
package pp5_pkg;

	// C = 1.01346 and D = 1.2158542 in unsigned Q1.30
	localparam logic [30:0] C_Q30    = 31'd1088194389;
	localparam logic [30:0] C_HALF   = 31'd544097194;
	localparam logic [30:0] D_Q30    = 31'd1305513506;
	localparam logic [36:0] ONE_Q26  = 37'd67108864;

	// floor(2^60 / C), and 2C, 3C for the quotient fix-up
	localparam logic [30:0] RCP_C    = 31'd1059481206;
	localparam logic [33:0] C_X2     = 34'd2176388778;
	localparam logic [33:0] C_X3     = 34'd3264583167;

	// coefficient register reset values, P5 (A = 2.0, B = 1.0)
	localparam logic [17:0] COEF_A_RST = 18'd131072;
	localparam logic [17:0] COEF_B_RST = 18'd65536;

	// register indexes
	localparam logic REG_COEF_A = 1'b0;
	localparam logic REG_COEF_B = 1'b1;

	// action codes
	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_INV = 1'b1;

	// sideband carried with every request; second holds |in_second| until the
	// second output is known, then the finished second output
	typedef struct packed {
		logic        act;
		logic        n1;
		logic        n2;
		logic [31:0] m1;
		logic [31:0] second;
	} side_t;

	// magnitude of a two's complement word (the most negative maps to 2^31)
	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

	// apply sign to a magnitude and clamp to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic [33:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (mag >= 34'h080000000) r = 32'h80000000;
			else                      r = 32'(34'd0 - mag);
		end else begin
			if (mag > 34'h07FFFFFFF) r = 32'h7FFFFFFF;
			else                     r = mag[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/putnins_p5_projection.sv =====
// ----------------------------------------------------------------------------
// putnins_p5_projection: Putnins P5 / P5' projection, forward and inverse
// Throughput: one request per cycle while the skid slot is empty; every stage
// holds one point, and the depth comes from the 31-stage longitude divider and
// the 32-stage square root.
// Reset clears all valid bits and loads the P5 coefficients (A = 2, B = 1).
// ----------------------------------------------------------------------------
module putnins_p5_projection (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [17:0] cfg_wdata,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] in_first, [63:32] in_second
	input  logic        s_tuser,   // [0] action
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] out_first, [63:32] out_second
	output logic        m_tuser    // [0] div_fault
);

	// ------------------------------------------------------------------
	// Coefficient registers
	// ------------------------------------------------------------------
	logic [17:0] coef_a_q;
	logic [17:0] coef_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= pp5_pkg::COEF_A_RST;
			coef_b_q <= pp5_pkg::COEF_B_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pp5_pkg::REG_COEF_A: coef_a_q <= cfg_wdata;
				pp5_pkg::REG_COEF_B: coef_b_q <= cfg_wdata;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipeline advances while the skid slot is
	// empty; the output register plus skid slot absorb the one request
	// that may arrive in the cycle the output stalls.
	// ------------------------------------------------------------------
	logic adv;
	logic sv_q;
	assign adv      = ~sv_q;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// Stages 1..4: phi = round(|y| * 2^30 / C) by reciprocal multiply.
	// The estimate floor(|y| * RCP / 2^30) trails the quotient by at most
	// three; compares of the remainder against C, 2C and 3C finish it.
	// Forward requests ride along and ignore the quotient.
	// ------------------------------------------------------------------
	logic           v_s1, v_s2, v_s3, v_s4;
	pp5_pkg::side_t sd_s1, sd_s2, sd_s3, sd_s4;
	logic [62:0]    rp_s2;
	logic [30:0]    est_s3;
	logic [61:0]    ec_s3;
	logic [30:0]    phi_s4;

	pp5_pkg::side_t in_sd;
	logic [30:0]    est_c;
	logic [33:0]    rem_c;
	logic [1:0]     fix_c;
	logic [30:0]    phi_sum;

	always_comb begin
		in_sd.act    = s_tuser;
		in_sd.n1     = s_tdata[31];
		in_sd.n2     = s_tdata[63];
		in_sd.m1     = pp5_pkg::mag32(s_tdata[31:0]);
		in_sd.second = pp5_pkg::mag32(s_tdata[63:32]);
		est_c        = rp_s2[60:30];
		// low bits of |y| * 2^30 + C/2 - est * C; the full remainder is below 4C
		rem_c        = {sd_s3.second[3:0], 30'd0} + {3'd0, pp5_pkg::C_HALF} - ec_s3[33:0];
		if (rem_c >= pp5_pkg::C_X3)                 fix_c = 2'd3;
		else if (rem_c >= pp5_pkg::C_X2)            fix_c = 2'd2;
		else if (rem_c >= {3'd0, pp5_pkg::C_Q30})   fix_c = 2'd1;
		else                                        fix_c = 2'd0;
		phi_sum      = est_s3 + {29'd0, fix_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1  <= in_sd;

			sd_s2  <= sd_s1;
			rp_s2  <= sd_s1.second * pp5_pkg::RCP_C;

			sd_s3  <= sd_s2;
			est_s3 <= est_c;
			ec_s3  <= est_c * pp5_pkg::C_Q30;

			sd_s4  <= sd_s3;
			phi_s4 <= phi_sum;
		end
	end

	// ------------------------------------------------------------------
	// Stages 5..7: phi squared, D*phi^2 partial products, y = C*phi
	// ------------------------------------------------------------------
	logic           v_s5, v_s6, v_s7;
	pp5_pkg::side_t sd_s5, sd_s6, sd_s7;
	logic [63:0]    pp_s5;
	logic [36:0]    p2_s6;
	logic [62:0]    ym_s6;
	logic [50:0]    dlo_s7;
	logic [47:0]    dhi_s7;

	logic [31:0]    phi_c;
	logic [63:0]    p2_rnd;
	logic [62:0]    y_rnd;
	logic [33:0]    sec_mag;
	pp5_pkg::side_t sd_c5;
	pp5_pkg::side_t sd_c7;

	always_comb begin
		// inverse uses the quotient as phi, forward uses |in_second|
		phi_c   = (sd_s4.act == pp5_pkg::ACT_INV) ? {1'b0, phi_s4} : sd_s4.second;
		p2_rnd  = pp_s5 + 64'd33554432;
		y_rnd   = ym_s6 + 63'd536870912;
		sec_mag = (sd_s6.act == pp5_pkg::ACT_INV) ? {2'b00, sd_s6.second}
		                                          : {1'b0, y_rnd[62:30]};
		sd_c5        = sd_s4;
		sd_c5.second = phi_c;
		// finished second output: saturated y (forward) or phi (inverse)
		sd_c7        = sd_s6;
		sd_c7.second = pp5_pkg::sat32(sec_mag, sd_s6.n2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s5  <= sd_c5;
			pp_s5  <= phi_c * phi_c;

			sd_s6  <= sd_s5;
			p2_s6  <= p2_rnd[62:26];
			ym_s6  <= sd_s5.second * pp5_pkg::C_Q30;

			sd_s7  <= sd_c7;
			dlo_s7 <= p2_s6[19:0] * pp5_pkg::D_Q30;
			dhi_s7 <= p2_s6[36:20] * pp5_pkg::D_Q30;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8 / square root: floor sqrt of (1 + D*phi^2) << 26, two
	// radicand bits a stage, 32 stages.
	// ------------------------------------------------------------------
	logic           sq_v_s   [0:32];
	pp5_pkg::side_t sq_sd_s  [0:32];
	logic [31:0]    sq_r_s   [0:32];
	logic [33:0]    sq_rem_s [0:32];
	logic [63:0]    sq_low_s [0:32];

	logic [69:0]    dsum;
	logic [36:0]    s_val;

	always_comb begin
		dsum  = ({22'd0, dhi_s7} << 20) + {19'd0, dlo_s7} + 70'd536870912;
		s_val = pp5_pkg::ONE_Q26 + dsum[66:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  sq_v_s[0] <= 1'b0;
		else if (adv) sq_v_s[0] <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_sd_s[0]  <= sd_s7;
			sq_r_s[0]   <= 32'd0;
			sq_rem_s[0] <= 34'd0;
			sq_low_s[0] <= {1'b0, s_val, 26'd0};
		end
	end

	for (genvar j = 1; j < 33; j++) begin : g_sqrt
		logic [35:0] cur;
		logic [35:0] trial;
		logic        ge;
		logic [35:0] dif;

		always_comb begin
			cur   = {sq_rem_s[j-1], sq_low_s[j-1][63:62]};
			trial = {2'b00, sq_r_s[j-1], 2'b01};
			ge    = cur >= trial;
			dif   = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  sq_v_s[j] <= 1'b0;
			else if (adv) sq_v_s[j] <= sq_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_sd_s[j]  <= sq_sd_s[j-1];
				sq_r_s[j]   <= {sq_r_s[j-1][30:0], ge};
				sq_rem_s[j] <= ge ? dif[33:0] : cur[33:0];
				sq_low_s[j] <= {sq_low_s[j-1][61:0], 2'b00};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 41..45: round the root, B*sqrt, k = A - B*sqrt, then k times
	// |lam| (forward) or k times C (inverse) in two partial products.
	// ------------------------------------------------------------------
	logic           v_s41, v_s42, v_s43, v_s44, v_s45;
	pp5_pkg::side_t sd_s41, sd_s42, sd_s43, sd_s44, sd_s45;
	logic [31:0]    sq_s41;
	logic [49:0]    bsp_s42;
	logic [33:0]    kmag_s43;
	logic           kneg_s43, kneg_s44, kneg_s45;
	logic [48:0]    ml_s44;
	logic [48:0]    mh_s44;
	logic [39:0]    t_s45;

	logic           rnd_up;
	logic [49:0]    bs_rnd;
	logic [33:0]    av_c;
	logic [31:0]    bop_c;
	logic [66:0]    prod_c;
	logic [66:0]    tf_rnd;
	logic [66:0]    ti_rnd;

	always_comb begin
		rnd_up = sq_rem_s[32] > {2'b00, sq_r_s[32]};
		bs_rnd = bsp_s42 + 50'd32768;
		av_c   = {6'd0, coef_a_q, 10'd0};
		bop_c  = (sd_s43.act == pp5_pkg::ACT_INV) ? {1'b0, pp5_pkg::C_Q30} : sd_s43.m1;
		prod_c = ({18'd0, mh_s44} << 17) + {18'd0, ml_s44};
		tf_rnd = prod_c + 67'd33554432;
		ti_rnd = prod_c + 67'd536870912;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s41 <= 1'b0;
			v_s42 <= 1'b0;
			v_s43 <= 1'b0;
			v_s44 <= 1'b0;
			v_s45 <= 1'b0;
		end else if (adv) begin
			v_s41 <= sq_v_s[32];
			v_s42 <= v_s41;
			v_s43 <= v_s42;
			v_s44 <= v_s43;
			v_s45 <= v_s44;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s41   <= sq_sd_s[32];
			sq_s41   <= sq_r_s[32] + {31'd0, rnd_up};

			sd_s42   <= sd_s41;
			bsp_s42  <= coef_b_q * sq_s41;

			sd_s43   <= sd_s42;
			if (av_c >= bs_rnd[49:16]) begin
				kmag_s43 <= av_c - bs_rnd[49:16];
				kneg_s43 <= 1'b0;
			end else begin
				kmag_s43 <= bs_rnd[49:16] - av_c;
				kneg_s43 <= 1'b1;
			end

			sd_s44   <= sd_s43;
			kneg_s44 <= kneg_s43;
			ml_s44   <= kmag_s43[16:0] * bop_c;
			mh_s44   <= kmag_s43[33:17] * bop_c;

			sd_s45   <= sd_s44;
			kneg_s45 <= kneg_s44;
			// forward: t = k*|lam| in Q.26; inverse: den = C*k in Q.26
			t_s45    <= (sd_s44.act == pp5_pkg::ACT_INV) ? {3'd0, ti_rnd[66:30]}
			                                             : tf_rnd[65:26];
		end
	end

	// ------------------------------------------------------------------
	// Stage 46 / divider B: lam = round(|x| * 2^26 / den), one quotient
	// bit a stage. Quotients of 2^31 and up are flagged and saturated.
	// Forward requests carry t, clamped at 2^31 where x saturates anyway.
	// ------------------------------------------------------------------
	logic           db_v_s    [0:31];
	pp5_pkg::side_t db_sd_s   [0:31];
	logic [34:0]    db_rem_s  [0:31];
	logic [30:0]    db_low_s  [0:31];
	logic [30:0]    db_q_s    [0:31];
	logic [34:0]    db_den_s  [0:31];
	logic [31:0]    db_tc_s   [0:31];
	logic           db_kneg_s [0:31];
	logic           db_ovf_s  [0:31];
	logic           db_dz_s   [0:31];

	logic [34:0]    den_c;
	logic [57:0]    lnum_c;

	always_comb begin
		den_c  = t_s45[34:0];
		lnum_c = {sd_s45.m1, 26'd0} + {24'd0, den_c[34:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  db_v_s[0] <= 1'b0;
		else if (adv) db_v_s[0] <= v_s45;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			db_sd_s[0]   <= sd_s45;
			db_rem_s[0]  <= {8'd0, lnum_c[57:31]};
			db_low_s[0]  <= lnum_c[30:0];
			db_q_s[0]    <= 31'd0;
			db_den_s[0]  <= den_c;
			db_tc_s[0]   <= (t_s45 >= 40'h0080000000) ? 32'h80000000 : t_s45[31:0];
			db_kneg_s[0] <= kneg_s45;
			db_ovf_s[0]  <= {8'd0, lnum_c[57:31]} >= den_c;
			db_dz_s[0]   <= den_c == 35'd0;
		end
	end

	for (genvar j = 1; j < 32; j++) begin : g_div_b
		logic [35:0] cur;
		logic        ge;
		logic [35:0] dif;

		always_comb begin
			cur = {db_rem_s[j-1], db_low_s[j-1][30]};
			ge  = cur >= {1'b0, db_den_s[j-1]};
			dif = cur - {1'b0, db_den_s[j-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  db_v_s[j] <= 1'b0;
			else if (adv) db_v_s[j] <= db_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				db_sd_s[j]   <= db_sd_s[j-1];
				db_rem_s[j]  <= ge ? dif[34:0] : cur[34:0];
				db_low_s[j]  <= {db_low_s[j-1][29:0], 1'b0};
				db_q_s[j]    <= {db_q_s[j-1][29:0], ge};
				db_den_s[j]  <= db_den_s[j-1];
				db_tc_s[j]   <= db_tc_s[j-1];
				db_kneg_s[j] <= db_kneg_s[j-1];
				db_ovf_s[j]  <= db_ovf_s[j-1];
				db_dz_s[j]   <= db_dz_s[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 78..79: x = C*t for forward, pick and saturate the first
	// output, raise the fault on a zero inverse denominator.
	// ------------------------------------------------------------------
	logic           v_s78, v_s79;
	pp5_pkg::side_t sd_s78;
	logic [62:0]    xp_s78;
	logic [30:0]    lam_s78;
	logic           kneg_s78, ovf_s78, dz_s78;
	logic [64:0]    res_s79;   // {div_fault, out_second, out_first}

	logic [62:0]    x_rnd;
	logic           neg_c;
	logic [31:0]    out1_c;
	logic           inv_c;

	always_comb begin
		x_rnd = xp_s78 + 63'd536870912;
		neg_c = sd_s78.n1 ^ kneg_s78;
		inv_c = sd_s78.act == pp5_pkg::ACT_INV;
		if (!inv_c)       out1_c = pp5_pkg::sat32({1'b0, x_rnd[62:30]}, neg_c);
		else if (dz_s78)  out1_c = 32'd0;
		else if (ovf_s78) out1_c = pp5_pkg::sat32(34'h080000000, neg_c);
		else              out1_c = pp5_pkg::sat32({3'b000, lam_s78}, neg_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s78 <= 1'b0;
			v_s79 <= 1'b0;
		end else if (adv) begin
			v_s78 <= db_v_s[31];
			v_s79 <= v_s78;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s78   <= db_sd_s[31];
			xp_s78   <= db_tc_s[31] * pp5_pkg::C_Q30;
			lam_s78  <= db_q_s[31];
			kneg_s78 <= db_kneg_s[31];
			ovf_s78  <= db_ovf_s[31];
			dz_s78   <= db_dz_s[31];

			res_s79  <= {inv_c & dz_s78, sd_s78.second, out1_c};
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid slot
	// ------------------------------------------------------------------
	logic        ov_q;
	logic [64:0] od_q;
	logic [64:0] sd_q;
	logic        push;

	assign push = adv & v_s79;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (!ov_q || m_tready) begin
			// output slot frees: drain the skid first, else take the new result
			ov_q <= sv_q | push;
			sv_q <= 1'b0;
		end else if (push) begin
			// output held: park the arriving result
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || m_tready) begin
			od_q <= sv_q ? sd_q : res_s79;
		end else if (push) begin
			sd_q <= res_s79;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q[63:0];
	assign m_tuser  = od_q[64];

endmodule

// ===== tb/sv/putnins_p5_projection_tb.sv =====
// ----------------------------------------------------------------------------
// putnins_p5_projection_tb: self-checking bench for the P5 / P5' projection
// Drives forward and inverse point requests through the stream ports under
// several coefficient settings, predicts every result with a bit-exact
// fixed-point model of the projection and compares it field by field.
// ----------------------------------------------------------------------------
module putnins_p5_projection_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// one point request and one projected point
	typedef struct {
		logic        act;
		logic [31:0] first;
		logic [31:0] second;
	} point_req_t;

	typedef struct {
		logic [31:0] first;
		logic [31:0] second;
		logic        fault;
	} point_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = pp5_pkg::REG_COEF_A;
	logic [17:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;    // [31:0] in_first, [63:32] in_second
	logic        s_tuser = pp5_pkg::ACT_FWD; // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;         // [31:0] out_first, [63:32] out_second
	logic        m_tuser;         // [0] div_fault

	putnins_p5_projection uut (.*);

	// mirror of the coefficient registers, changed only while the block is idle
	logic [17:0] coef_a_mir = pp5_pkg::COEF_A_RST;
	logic [17:0] coef_b_mir = pp5_pkg::COEF_B_RST;

	point_req_t pending_pts[$];
	point_res_t projected_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 130;

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	// round(a*b / 2^sh), exact in 128 bits
	function automatic logic [127:0] mul_rnd(input logic [127:0] a, input logic [127:0] b,
			input int sh);
		return (a * b + (128'd1 << (sh - 1))) >> sh;
	endfunction

	// integer square root rounded to nearest
	function automatic logic [63:0] sqrt_rnd(input logic [63:0] n0);
		logic [63:0] n, r, b;
		n = n0;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (n > r) r = r + 1;
		return r;
	endfunction

	function automatic logic [127:0] mag_of(input logic [31:0] v);
		return v[31] ? (128'h1_0000_0000 - v) : {96'd0, v};
	endfunction

	function automatic logic [31:0] clamp32(input logic [127:0] m, input logic neg);
		if (neg) return (m >= 128'h8000_0000) ? 32'h8000_0000 : 32'(128'd0 - m);
		return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	// k(phi) = A - B*sqrt(1 + D*phi^2) as magnitude and sign, Q.26
	function automatic void shape_factor(input logic [127:0] phim, output logic [127:0] km,
			output logic kneg);
		logic [127:0] p2, s, sq, bs, av;
		p2 = (phim * phim + (128'd1 << 25)) >> 26;
		s = pp5_pkg::ONE_Q26 + mul_rnd(p2, pp5_pkg::D_Q30, 30);
		sq = sqrt_rnd(64'(s << 26));
		bs = (coef_b_mir * sq + (128'd1 << 15)) >> 16;
		av = {110'd0, coef_a_mir} << 10;
		kneg = av < bs;
		km = kneg ? bs - av : av - bs;
	endfunction

	function automatic point_res_t project_point(input point_req_t p);
		point_res_t r;
		logic [127:0] m1, m2, km, t, phi, den;
		logic n1, n2, kneg;
		m1 = mag_of(p.first);
		m2 = mag_of(p.second);
		n1 = p.first[31];
		n2 = p.second[31];
		r.fault = 1'b0;
		if (p.act == pp5_pkg::ACT_FWD) begin
			shape_factor(m2, km, kneg);
			t = mul_rnd(km, m1, 26);
			r.first = clamp32(mul_rnd(t, pp5_pkg::C_Q30, 30), n1 != kneg);
			r.second = clamp32(mul_rnd(m2, pp5_pkg::C_Q30, 30), n2);
		end else begin
			phi = ((m2 << 30) + (pp5_pkg::C_Q30 >> 1)) / pp5_pkg::C_Q30;
			shape_factor(phi, km, kneg);
			den = mul_rnd(km, pp5_pkg::C_Q30, 30);
			r.second = clamp32(phi, n2);
			if (den == 0) begin
				r.first = '0;
				r.fault = 1'b1;
			end else begin
				r.first = clamp32(((m1 << 26) + (den >> 1)) / den, n1 != kneg);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------- driver
	// advance to the next queued point when the slot is free; record the
	// prediction for every request the block takes
	always @(posedge clk or negedge arst_n) begin
		point_req_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				projected_q.push_back(project_point(
					point_req_t'{s_tuser, s_tdata[31:0], s_tdata[63:32]}));
			if (!s_tvalid || s_tready) begin
				if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					p = pending_pts.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= p.act;
					s_tdata <= {p.second, p.first};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------ monitor
	always @(posedge clk or negedge arst_n) begin
		point_res_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (projected_q.size() == 0) begin
					$error("result with no request outstanding: %h %b", m_tdata, m_tuser);
					errors++;
				end else begin
					e = projected_q.pop_front();
					if (m_tdata[31:0] !== e.first) begin
						$error("out_first: expected %h, got %h", e.first, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== e.second) begin
						$error("out_second: expected %h, got %h", e.second, m_tdata[63:32]);
						errors++;
					end
					if (m_tuser !== e.fault) begin
						$error("div_fault: expected %b, got %b", e.fault, m_tuser);
						errors++;
					end
				end
			end
		end
	end

	// ----------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("putnins_p5_projection_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------ stimulus
	// both registers back to back, then drop the write enable
	task automatic load_coefs(input logic [17:0] a, input logic [17:0] b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= pp5_pkg::REG_COEF_A;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_idx <= pp5_pkg::REG_COEF_B;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		coef_a_mir = a;
		coef_b_mir = b;
	endtask

	task automatic queue_point(input logic act, input logic [31:0] f, input logic [31:0] s);
		pending_pts.push_back(point_req_t'{act, f, s});
	endtask

	// mostly map-range coordinates, with full-range words, tiny values and
	// the word extremes mixed in
	function automatic logic [31:0] coord();
		logic [31:0] picks[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF};
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: return 32'($urandom_range(2000)) - 32'd1000;
			3: return picks[$urandom_range(4)];
			default: return 32'($urandom_range(421657428)) - 32'd210828714;
		endcase
	endfunction

	task automatic queue_random(input int n);
		repeat (n) queue_point($urandom_range(1) ? pp5_pkg::ACT_INV : pp5_pkg::ACT_FWD,
			coord(), coord());
	endtask

	// hold until every request went in and every result came back, then let
	// the pipeline drain before anything touches the registers
	task automatic settle();
		while (pending_pts.size() != 0 || projected_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [31:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
		logic [31:0] y;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: word extremes in both directions at the reset coefficients
		send_idle_pct = 19;
		recv_idle_pct = 74;
		foreach (ext[i]) begin
			queue_point(pp5_pkg::ACT_FWD, ext[i], ext[3 - i]);
			queue_point(pp5_pkg::ACT_INV, ext[i], ext[3 - i]);
		end
		queue_point(pp5_pkg::ACT_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(pp5_pkg::ACT_INV, 32'h8000_0000, 32'h8000_0000);
		queue_point(pp5_pkg::ACT_FWD, 32'd210828714, 32'd105414357);  // lam = pi at the pole
		queue_point(pp5_pkg::ACT_FWD, -32'd210828714, -32'd35000000);
		queue_point(pp5_pkg::ACT_INV, 32'd150000000, 32'd50000000);
		queue_point(pp5_pkg::ACT_INV, -32'd150000000, -32'd90000000);
		queue_point(pp5_pkg::ACT_INV, 32'd1, 32'd106833226);          // near y at the pole
		// find a y at which the P5 denominator rounds to zero
		for (int d = 0; d < 60000; d++) begin
			y = 32'd106800000 + d;
			if (project_point(point_req_t'{pp5_pkg::ACT_INV, 32'd1000, y}).fault) begin
				queue_point(pp5_pkg::ACT_INV, 32'd70000000, y);
				queue_point(pp5_pkg::ACT_INV, -32'd5, -y);
				break;
			end
		end
		settle();

		// P5 prime
		load_coefs(18'd98304, 18'd32768);
		queue_random(400);
		settle();

		// largest coefficients, receiver now eager and sender lazy
		send_idle_pct = 74;
		recv_idle_pct = 19;
		load_coefs(18'h3FFFF, 18'h3FFFF);
		queue_random(300);
		settle();

		// zero coefficients: every inverse point hits the zero denominator
		load_coefs(18'd0, 18'd0);
		queue_random(60);
		settle();

		// random coefficients, then P5 again, with no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_coefs(18'($urandom), 18'($urandom));
		queue_random(300);
		settle();
		load_coefs(pp5_pkg::COEF_A_RST, pp5_pkg::COEF_B_RST);
		queue_random(220);
		settle();

		if (errors == 0) $display("putnins_p5_projection_tb: clean");
		else $display("putnins_p5_projection_tb: errors");
		$finish;
	end

endmodule
